// ===== rtl/wcpt_pkg.sv =====
// ----------------------------------------------------------------------------
// wcpt_pkg
// Shared types and constants of the window charge and peak time unit.
// ----------------------------------------------------------------------------
package wcpt_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int SAMPLE_BITS = 16;

  localparam int IDX_W   = $clog2(MAX_SAMPLES + 1);
  localparam int POS_W   = $clog2(MAX_SAMPLES);
  localparam int PEAK_W  = 10;
  localparam int WIDTH_W = 11;
  localparam int SHIFT_W = 10;
  localparam int PER_W   = 24;
  localparam int CHG_W   = 26;
  localparam int WS_W    = 36;
  localparam int PS_W    = 26;
  localparam int PT_W    = 24;

  // Window arithmetic: start can go down to -1023, end up to 3070.
  localparam int WIN_W = 13;
  localparam int CMP_W = (IDX_W + 1 > WIN_W) ? IDX_W + 1 : WIN_W;
  localparam int PROD_W = SAMPLE_BITS - 1 + POS_W;
  localparam int MAC_W  = ((WS_W > PROD_W) ? WS_W : PROD_W) + 1;

  // Back end arithmetic.
  localparam int HALF_W = (WS_W + 1) / 2;
  localparam int MUL_W  = HALF_W + PER_W;
  localparam int NUM_W  = WS_W + PER_W + 1;
  localparam int Q_W    = PT_W + 1;
  localparam int CNT_W  = $clog2(PT_W + 1);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd2;

  localparam logic [WIDTH_W-1:0] WIDTH_RST  = 11'd7;
  localparam logic [SHIFT_W-1:0] SHIFT_RST  = 10'd3;
  localparam logic [PER_W-1:0]   PERIOD_RST = 24'd65536;

  typedef struct packed {
    logic [WIDTH_W-1:0] window_width;
    logic [SHIFT_W-1:0] window_shift;
    logic [PER_W-1:0]   sample_period;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic [PEAK_W-1:0]             peak_pos;
    logic                          last_sample;
  } in_t;

  typedef struct packed {
    logic signed [CHG_W-1:0] charge;
    logic [PT_W-1:0]         peak_time_ns;
    logic                    used_fallback;
  } out_t;

  // One finished waveform handed from the front end to the back end.
  typedef struct packed {
    logic [PEAK_W-1:0]       held_peak;
    logic signed [CHG_W-1:0] charge;
    logic [WS_W-1:0]         weighted_sum;
    logic [PS_W-1:0]         positive_sum;
  } job_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL_LO,
    B_MUL_HI,
    B_DIV,
    B_DONE
  } back_state_t;

endpackage

// ===== rtl/wcpt_front.sv =====
// ----------------------------------------------------------------------------
// wcpt_front
// Per-sample window test and saturating charge, positive and weighted sums.
// ----------------------------------------------------------------------------
module wcpt_front import wcpt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  in_t   in_data,
  input  logic  q_full,
  output logic  q_push,
  output job_t  q_job
);

  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [PEAK_W-1:0]       held_r, held_nxt;
  logic signed [CHG_W-1:0] charge_r, charge_nxt;
  logic [WS_W-1:0]         wsum_r, wsum_nxt;
  logic [PS_W-1:0]         psum_r, psum_nxt;

  logic [PEAK_W-1:0]       peak_now;
  logic signed [WIN_W-1:0] start_s, end_s, start_c;
  logic signed [CMP_W-1:0] idx_c, st_c, end_c;
  logic                    in_range, in_win, accept, positive;
  logic signed [CHG_W:0]   csum;
  logic [PS_W:0]           psum_w;
  logic [PROD_W-1:0]       prod;
  logic [MAC_W-1:0]        wsum_w;
  logic [SAMPLE_BITS-2:0]  mag;
  logic signed [CHG_W-1:0] charge_up;
  logic [WS_W-1:0]         wsum_up;
  logic [PS_W-1:0]         psum_up;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    peak_now = (idx_r == '0) ? in_data.peak_pos : held_r;
    start_s  = $signed({{(WIN_W-PEAK_W){1'b0}}, peak_now})
             - $signed({{(WIN_W-SHIFT_W){1'b0}}, cfg.window_shift});
    end_s    = start_s + $signed({{(WIN_W-WIDTH_W){1'b0}}, cfg.window_width});
    start_c  = start_s[WIN_W-1] ? '0 : start_s;
    idx_c    = $signed({{(CMP_W-IDX_W){1'b0}}, idx_r});
    st_c     = CMP_W'(start_c);
    end_c    = CMP_W'(end_s);
    in_range = idx_r < IDX_W'(MAX_SAMPLES);
    in_win   = in_range && (idx_c >= st_c) && (idx_c < end_c);

    positive = !in_data.sample_value[SAMPLE_BITS-1] && (in_data.sample_value != '0);
    mag      = in_data.sample_value[SAMPLE_BITS-2:0];

    // Charge saturates to the signed range when the extra sign bit disagrees.
    csum = (CHG_W+1)'(charge_r) + (CHG_W+1)'(in_data.sample_value);
    if (csum[CHG_W] != csum[CHG_W-1]) begin
      charge_up = csum[CHG_W] ? {1'b1, {(CHG_W-1){1'b0}}} : {1'b0, {(CHG_W-1){1'b1}}};
    end else begin
      charge_up = csum[CHG_W-1:0];
    end

    psum_w  = {1'b0, psum_r} + (PS_W+1)'(mag);
    psum_up = psum_w[PS_W] ? '1 : psum_w[PS_W-1:0];

    prod    = PROD_W'(mag) * PROD_W'(idx_r[POS_W-1:0]);
    wsum_w  = MAC_W'(wsum_r) + MAC_W'(prod);
    wsum_up = (|wsum_w[MAC_W-1:WS_W]) ? '1 : wsum_w[WS_W-1:0];

    idx_nxt    = idx_r;
    held_nxt   = held_r;
    charge_nxt = charge_r;
    wsum_nxt   = wsum_r;
    psum_nxt   = psum_r;

    q_job.held_peak    = peak_now;
    q_job.charge       = in_win ? charge_up : charge_r;
    q_job.weighted_sum = (in_win && positive) ? wsum_up : wsum_r;
    q_job.positive_sum = (in_win && positive) ? psum_up : psum_r;
    q_push             = accept && in_data.last_sample;

    if (accept) begin
      if (in_data.last_sample) begin
        idx_nxt    = '0;
        held_nxt   = '0;
        charge_nxt = '0;
        wsum_nxt   = '0;
        psum_nxt   = '0;
      end else begin
        held_nxt   = peak_now;
        charge_nxt = q_job.charge;
        wsum_nxt   = q_job.weighted_sum;
        psum_nxt   = q_job.positive_sum;
        if (in_range) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      held_r   <= '0;
      charge_r <= '0;
      wsum_r   <= '0;
      psum_r   <= '0;
    end else begin
      idx_r    <= idx_nxt;
      held_r   <= held_nxt;
      charge_r <= charge_nxt;
      wsum_r   <= wsum_nxt;
      psum_r   <= psum_nxt;
    end
  end

endmodule

// ===== rtl/wcpt_queue.sv =====
// ----------------------------------------------------------------------------
// wcpt_queue
// Short FIFO of finished waveforms between the front end and the back end.
// ----------------------------------------------------------------------------
module wcpt_queue import wcpt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  job_t  push_job,
  output q_wr_t wr_stat,
  input  logic  pop,
  output logic  not_empty,
  output job_t  head
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign not_empty    = (cnt_r != '0);
  assign do_pop       = pop && not_empty;
  assign do_push      = push && (cnt_r != QCNT_W'(QDEPTH));
  assign wr_stat.push = do_push;
  assign wr_stat.full = (cnt_r == QCNT_W'(QDEPTH));
  assign head         = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == QPTR_W'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == QPTR_W'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/wcpt_back.sv =====
// ----------------------------------------------------------------------------
// wcpt_back
// Peak time from one waveform's sums: shared multiplier, bit-serial divider,
// saturation and the result register.
// ----------------------------------------------------------------------------
module wcpt_back import wcpt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic [PER_W-1:0] period,
  input  logic  q_not_empty,
  input  job_t  q_head,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  back_state_t       state_r, state_nxt;
  job_t              job_r, job_nxt;
  logic              fb_r, fb_nxt;
  logic [NUM_W-1:0]  acc_r, acc_nxt;
  logic [NUM_W-1:0]  dsh_r, dsh_nxt;
  logic [Q_W-1:0]    q_r, q_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ovalid_r, ovalid_nxt;
  out_t              odata_r, odata_nxt;

  logic [HALF_W-1:0] mul_a;
  logic [MUL_W-1:0]  prod;
  logic [NUM_W-1:0]  addend, fb_shift;
  logic              ge, out_free;
  logic [PT_W-1:0]   pt_val;

  assign out_valid = ovalid_r;
  assign out_data  = odata_r;
  assign out_free  = !ovalid_r || out_ready;

  always_comb begin
    if (state_r == B_MUL_HI) begin
      mul_a = job_r.weighted_sum[WS_W-1:HALF_W];
    end else if (fb_r) begin
      mul_a = HALF_W'(job_r.held_peak);
    end else begin
      mul_a = job_r.weighted_sum[HALF_W-1:0];
    end
    prod = MUL_W'(mul_a) * MUL_W'(period);

    // The rounding term is half of the divisor, or half of the Q8 step.
    addend   = fb_r ? NUM_W'(128) : NUM_W'({job_r.positive_sum, 7'b0});
    ge       = acc_r >= dsh_r;
    fb_shift = acc_r >> 8;
    if (fb_r) begin
      pt_val = (|fb_shift[NUM_W-1:PT_W]) ? '1 : fb_shift[PT_W-1:0];
    end else begin
      pt_val = q_r[PT_W] ? '1 : q_r[PT_W-1:0];
    end

    state_nxt  = state_r;
    job_nxt    = job_r;
    fb_nxt     = fb_r;
    acc_nxt    = acc_r;
    dsh_nxt    = dsh_r;
    q_nxt      = q_r;
    cnt_nxt    = cnt_r;
    q_pop      = 1'b0;
    ovalid_nxt = ovalid_r && !out_ready;
    odata_nxt  = odata_r;

    case (state_r)
      B_IDLE: begin
        if (q_not_empty) begin
          q_pop     = 1'b1;
          job_nxt   = q_head;
          fb_nxt    = (q_head.positive_sum == '0);
          state_nxt = B_MUL_LO;
        end
      end
      B_MUL_LO: begin
        acc_nxt   = addend + NUM_W'(prod);
        state_nxt = fb_r ? B_DONE : B_MUL_HI;
      end
      B_MUL_HI: begin
        acc_nxt   = acc_r + (NUM_W'(prod) << HALF_W);
        dsh_nxt   = NUM_W'({job_r.positive_sum, 8'b0}) << PT_W;
        q_nxt     = '0;
        cnt_nxt   = CNT_W'(PT_W);
        state_nxt = B_DIV;
      end
      B_DIV: begin
        // Restoring division; the top quotient bit flags saturation.
        if (ge) begin
          acc_nxt = acc_r - dsh_r;
        end
        q_nxt   = {q_r[Q_W-2:0], ge};
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          ovalid_nxt              = 1'b1;
          odata_nxt.charge        = job_r.charge;
          odata_nxt.peak_time_ns  = pt_val;
          odata_nxt.used_fallback = fb_r;
          state_nxt               = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    fb_r    <= fb_nxt;
    acc_r   <= acc_nxt;
    dsh_r   <= dsh_nxt;
    q_r     <= q_nxt;
    cnt_r   <= cnt_nxt;
    odata_r <= odata_nxt;
  end

endmodule

// ===== rtl/window_charge_peak_time_unit.sv =====
// ----------------------------------------------------------------------------
// window_charge_peak_time_unit
// Fixed-window charge and weighted peak time of a streamed waveform.
// ----------------------------------------------------------------------------
// Samples enter on the in_ channel, one transfer per sample, with the flag
// last_sample on the final sample of a waveform. The front end takes one
// sample per cycle and keeps the window sums; on the last sample it places
// the sums in a two-entry queue. The back end turns each queued waveform into
// one result on the out_ channel.
// Per waveform the back end pops the queue, runs one multiply of 18 by 24
// bits in each of two states (B_MUL_LO, B_MUL_HI), then a restoring divider
// that retires one quotient bit per cycle (B_DIV), and loads the result
// register in B_DONE; when no positive sample fell in the window it goes from
// B_MUL_LO straight to B_DONE. Samples keep streaming at one per cycle while
// the queue has room; in_ready drops while both queue entries are taken.
// A stalled receiver holds the result register; the back end then waits with
// its next result, and the queue fills before the input stalls.
// Reset clears the sums, empties the queue, drops out_valid and loads the
// register defaults (width 7, shift 3, period 256 ns). The cfg_ port writes
// a register; the user must use it only while idle: the block does not check.
// ----------------------------------------------------------------------------
module window_charge_peak_time_unit import wcpt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data
);

  cfg_t  cfg_r, cfg_nxt;
  q_wr_t q_stat;
  logic  f_push, q_pop, q_not_empty;
  job_t  f_job, q_head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  cfg_nxt.window_width  = cfg_wdata[WIDTH_W-1:0];
        CFG_SHIFT:  cfg_nxt.window_shift  = cfg_wdata[SHIFT_W-1:0];
        CFG_PERIOD: cfg_nxt.sample_period = cfg_wdata[PER_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_width  <= WIDTH_RST;
      cfg_r.window_shift  <= SHIFT_RST;
      cfg_r.sample_period <= PERIOD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  wcpt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_stat.full),
    .q_push   (f_push),
    .q_job    (f_job)
  );

  wcpt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_job  (f_job),
    .wr_stat   (q_stat),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  wcpt_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .period      (cfg_r.sample_period),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// ===== rtl/wcpt_checker.sv =====
// ----------------------------------------------------------------------------
// wcpt_checker
// Port-level checks of the window charge and peak time unit.
// ----------------------------------------------------------------------------
module wcpt_checker import wcpt_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // A result waiting for transfer holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Without a positive sample in the window the charge cannot be positive.
  a_fallback_charge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.used_fallback |-> out_data.charge <= 0)
    else $error("fallback result with positive charge");

  // The queue is empty after reset, so the input is ready right away.
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind window_charge_peak_time_unit wcpt_checker u_wcpt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
